// ===== hdl/plah_pkg.sv =====
// Shared types and constants for the piecewise-linear angle-to-height linearizer.
package plah_pkg;

    // Field widths
    localparam int ANGLE_W    = 16;
    localparam int HEIGHT_W   = 16;
    localparam int IDX_W      = 3;
    localparam int SEG_W      = 2;
    // Difference operands are one bit wider than the fields
    localparam int DIFF_W     = ANGLE_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    // |num| <= 65535 * 65535, so the magnitude fits 32 bits
    localparam int DIVIDEND_W = 2 * ANGLE_W;
    // h_lo plus a signed quotient
    localparam int SUM_W      = DIVIDEND_W + 3;

    localparam int POINTS_DEFAULT = 5;

    // Item commands
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic [IDX_W-1:0]           point_index;
        logic [ANGLE_W-1:0]         point_angle;
        logic signed [HEIGHT_W-1:0] point_height;
        logic [ANGLE_W-1:0]         query_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height_out;
        logic                       saturated;
        logic                       degenerate;
        logic [SEG_W-1:0]           segment_used;
    } t_out_item;

endpackage

// ===== hdl/plah_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module plah_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [plah_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [plah_pkg::ANGLE_W-1:0]        i_divisor,
    output logic                                o_done,
    output logic [plah_pkg::DIVIDEND_W-1:0]     o_quotient
);

    localparam int NW = plah_pkg::DIVIDEND_W;
    localparam int DW = plah_pkg::ANGLE_W;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   shifted;
    logic [DW:0]   trial;
    logic          q_bit;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        shifted = {r_rem, r_quo[NW-1]};
        trial   = shifted - {1'b0, r_den};
        q_bit   = ~trial[DW];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], q_bit};
            // a failed trial leaves a value below the divisor
            r_rem <= q_bit ? trial[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/piecewise_linear_angle_to_height.sv =====
// Top level of the piecewise-linear angle-to-height linearizer.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) takes two kinds of item.
// A write item stores one calibration point (angle, height) into slot
// point_index; it gives no result, and slots at or past POINTS are ignored.
// A convert item sorts a copy of the table by angle, picks the segment
// holding query_angle (extrapolating past either end) and interpolates; it
// gives one item on the output channel
// (o_out_valid / i_out_stall / o_out_item).
// A convert item runs the exchange sort through the working shift line,
// the segment search, the multiply and the bit-serial 32-step divider, then
// waits in a done state; a segment with equal end angles skips the divider.
// The input stalls while a conversion runs. A finished result sits in the
// output register; when the receiver stalls, the block holds the next result
// until the register frees and accepts a new item meanwhile only after that.
// Synchronous reset clears the table to all zero and empties the output.
module piecewise_linear_angle_to_height #(
    parameter int POINTS = plah_pkg::POINTS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  plah_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output plah_pkg::t_out_item o_out_item
);

    localparam int AW  = plah_pkg::ANGLE_W;
    localparam int HW  = plah_pkg::HEIGHT_W;
    localparam int SW  = $clog2(POINTS);
    localparam int XW  = 5;
    localparam int DFW = plah_pkg::DIFF_W;
    localparam int PW  = plah_pkg::PROD_W;
    localparam int NW  = plah_pkg::DIVIDEND_W;
    localparam int VW  = plah_pkg::SUM_W;
    localparam logic signed [VW-1:0] VMAX = VW'(32767);
    localparam logic signed [VW-1:0] VMIN = -VW'(32768);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SORT = 7'b0000010,
        S_PREP = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_MULT = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Calibration table and working line (w[POINTS-1] is the sort's current slot)
    logic [AW-1:0]        r_tab_a [POINTS];
    logic signed [HW-1:0] r_tab_h [POINTS];
    logic [AW-1:0]        r_wa    [POINTS];
    logic signed [HW-1:0] r_wh    [POINTS];

    logic [SW-1:0]        r_pass;
    logic [SW-1:0]        r_step;
    logic [AW-1:0]        r_q;
    logic                 r_low;
    logic                 r_high;
    logic [AW-1:0]        r_den;
    logic signed [PW-1:0] r_prod;
    logic                 r_div_start;
    plah_pkg::t_out_item  r_res;
    logic                 r_out_valid;
    plah_pkg::t_out_item  r_out;

    logic                 in_acc;
    logic                 out_free;
    logic [XW-1:0]        idx_ext;
    logic                 cmp_en;
    logic                 last_step;
    logic                 last_pass;
    logic                 swap;
    logic [AW-1:0]        push_a;
    logic signed [HW-1:0] push_h;
    logic [AW-1:0]        cur_a;
    logic signed [HW-1:0] cur_h;
    logic                 stop;
    logic signed [DFW-1:0] dq;
    logic signed [DFW-1:0] dh;
    logic [AW-1:0]        den_c;
    logic signed [PW-1:0] prod_mag;
    logic                 div_done;
    logic [NW-1:0]        quo;
    logic signed [VW-1:0] quo_s;
    logic signed [VW-1:0] val;
    logic                 w_sorted;
    logic [XW-1:0]        seg_ext;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign idx_ext    = XW'(i_in_item.point_index);
    assign seg_ext    = XW'(r_step);

    // Exchange-sort step: compare current slot with the ring head
    always_comb begin
        cmp_en    = ({1'b0, r_step} + {1'b0, r_pass}) < (SW+1)'(POINTS - 1);
        last_step = (r_step == SW'(POINTS - 1));
        last_pass = (r_pass == SW'(POINTS - 2));
        swap      = last_step || (cmp_en && (r_wa[POINTS-1] > r_wa[0]));
        push_a    = swap ? r_wa[POINTS-1] : r_wa[0];
        push_h    = swap ? r_wh[POINTS-1] : r_wh[0];
        cur_a     = swap ? r_wa[0] : r_wa[POINTS-1];
        cur_h     = swap ? r_wh[0] : r_wh[POINTS-1];
    end

    // Segment search stop
    assign stop = r_low || (r_step == SW'(POINTS - 2)) || (!r_high && (r_q <= r_wa[1]));

    // Differences for the multiply
    always_comb begin
        dq    = $signed({1'b0, r_q}) - $signed({1'b0, r_wa[0]});
        dh    = $signed({r_wh[1][HW-1], r_wh[1]}) - $signed({r_wh[0][HW-1], r_wh[0]});
        den_c = r_wa[1] - r_wa[0];
    end

    // Operand magnitude, signed quotient and final sum
    always_comb begin
        prod_mag = r_prod[PW-1] ? -r_prod : r_prod;
        quo_s    = r_prod[PW-1] ? -$signed({3'b000, quo}) : $signed({3'b000, quo});
        val      = $signed({{(VW-HW){r_wh[0][HW-1]}}, r_wh[0]}) + quo_s;
    end

    plah_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (prod_mag[NW-1:0]),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc && i_in_item.cmd == plah_pkg::CMD_CONVERT) n_state = S_SORT;
            S_SORT: if (last_step && last_pass) n_state = S_PREP;
            S_PREP: n_state = S_SCAN;
            S_SCAN: if (stop) n_state = S_MULT;
            S_MULT: n_state = (den_c == '0) ? S_DONE : S_DIV;
            S_DIV:  if (div_done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= '0;
            r_step      <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= (r_state == S_MULT) && (den_c != '0);
            case (r_state)
                S_IDLE: begin
                    r_pass <= '0;
                    r_step <= '0;
                end
                S_SORT: begin
                    if (last_step) begin
                        r_step <= '0;
                        r_pass <= r_pass + 1'b1;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_PREP: r_step <= '0;
                S_SCAN: if (!stop) r_step <= r_step + 1'b1;
                default: ;
            endcase
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Calibration table, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < POINTS; k++) begin
                r_tab_a[k] <= '0;
                r_tab_h[k] <= '0;
            end
        end else if (in_acc && i_in_item.cmd == plah_pkg::CMD_WRITE) begin
            for (int k = 0; k < POINTS; k++) begin
                if (idx_ext == XW'(k)) begin
                    r_tab_a[k] <= i_in_item.point_angle;
                    r_tab_h[k] <= i_in_item.point_height;
                end
            end
        end
    end

    // Working line and datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_item.cmd == plah_pkg::CMD_CONVERT) begin
                    r_q <= i_in_item.query_angle;
                    r_wa[POINTS-1] <= r_tab_a[0];
                    r_wh[POINTS-1] <= r_tab_h[0];
                    for (int k = 0; k < POINTS - 1; k++) begin
                        r_wa[k] <= r_tab_a[k+1];
                        r_wh[k] <= r_tab_h[k+1];
                    end
                end
            end
            S_SORT: begin
                // ring is w[0..POINTS-2]; sorted slots trail behind the live ones
                for (int k = 0; k < POINTS - 2; k++) begin
                    r_wa[k] <= r_wa[k+1];
                    r_wh[k] <= r_wh[k+1];
                end
                r_wa[POINTS-2] <= push_a;
                r_wh[POINTS-2] <= push_h;
                r_wa[POINTS-1] <= cur_a;
                r_wh[POINTS-1] <= cur_h;
            end
            S_PREP: begin
                r_low  <= (r_q <= r_wa[0]);
                r_high <= (r_q >= r_wa[POINTS-1]);
            end
            S_SCAN: begin
                // rotate until w[0], w[1] hold the chosen segment
                if (!stop) begin
                    for (int k = 0; k < POINTS - 1; k++) begin
                        r_wa[k] <= r_wa[k+1];
                        r_wh[k] <= r_wh[k+1];
                    end
                    r_wa[POINTS-1] <= r_wa[0];
                    r_wh[POINTS-1] <= r_wh[0];
                end
            end
            S_MULT: begin
                r_den  <= den_c;
                r_prod <= dq * dh;
                if (den_c == '0) begin
                    r_res.height_out   <= '0;
                    r_res.saturated    <= 1'b0;
                    r_res.degenerate   <= 1'b1;
                    r_res.segment_used <= seg_ext[plah_pkg::SEG_W-1:0];
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_res.degenerate   <= 1'b0;
                    r_res.segment_used <= seg_ext[plah_pkg::SEG_W-1:0];
                    if (val > VMAX) begin
                        r_res.height_out <= VMAX[HW-1:0];
                        r_res.saturated  <= 1'b1;
                    end else if (val < VMIN) begin
                        r_res.height_out <= VMIN[HW-1:0];
                        r_res.saturated  <= 1'b1;
                    end else begin
                        r_res.height_out <= val[HW-1:0];
                        r_res.saturated  <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Sort check for the assertions
    always_comb begin
        w_sorted = 1'b1;
        for (int k = 0; k < POINTS - 1; k++) begin
            if (r_wa[k] > r_wa[k+1]) w_sorted = 1'b0;
        end
    end

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |-> w_sorted)
        else $error("working line not in angle order after sort");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished conversion");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.degenerate) |->
            (!o_out_item.saturated && o_out_item.height_out == '0))
        else $error("degenerate result carries a height or saturation");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> ((r_state == S_DIV) && (r_den != '0)))
        else $error("divider started outside divide or with zero divisor");

endmodule
